[design/fcca_pkg.sv]
// shared types and constants for the cluster chain allocator
`timescale 1ns / 1ps
`default_nettype none

package fcca_pkg;

    // transaction field widths
    localparam int BYTE_W   = 21;
    localparam int START_W  = 9;
    localparam int STATUS_W = 2;
    localparam int FIRST_W  = 9;
    localparam int COUNT_W  = 10;

    // cluster count of the largest request at the smallest cluster size
    localparam int NEED_W    = 12;

    localparam logic [BYTE_W-1:0] MAX_BYTES = BYTE_W'(1048576);

    // clusters 0 to 2 hold end marks after reset, search starts above them
    localparam int RESERVED_CLUSTERS = 3;
    localparam int FIRST_SEARCH      = 3;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_START = 2'd2;

    // which result the output register takes
    typedef logic [1:0] t_res;
    localparam t_res RES_ALLOC    = 2'd0;
    localparam t_res RES_FREE     = 2'd1;
    localparam t_res RES_NO_SPACE = 2'd2;
    localparam t_res RES_BAD      = 2'd3;

    typedef struct packed {
        logic                func;
        logic [BYTE_W-1:0]   byte_count;
        logic [START_W-1:0]  start_cluster;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIRST_W-1:0]  first_cluster;
        logic [COUNT_W-1:0]  cluster_total;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic div_step;
        logic scan_start;
        logic scan_step;
        logic link_step;
        logic walk_start;
        logic walk_step;
        logic out_load;
        t_res out_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic bad_start;
        logic oversize;
        logic clr_last;
        logic found;
        logic scan_last;
        logic link_last;
        logic walk_last;
    } t_sts;

endpackage

`default_nettype wire

[design/fcca_ram.sv]
// generic single write port ram with registered read, write-first on a shared address
`timescale 1ns / 1ps
`default_nettype none

module fcca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, new data when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/fcca_dpath.sv]
// datapath: link table, size divider, first-fit scan, chain link and walk
`timescale 1ns / 1ps
`default_nettype none

module fcca_dpath #(
    parameter int NUM_CLUSTERS  = 512,
    parameter int CLUSTER_BYTES = 2048
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fcca_pkg::t_in_item i_in_data,
    input  wire fcca_pkg::t_cmd     i_cmd,
    output fcca_pkg::t_sts          o_sts,
    output fcca_pkg::t_out_item     o_out_data
);
    import fcca_pkg::*;

    localparam int CW    = $clog2(NUM_CLUSTERS);
    localparam int CNT_W = $clog2(NUM_CLUSTERS + 1);
    localparam int LW    = CW + 1;
    localparam int XW    = CW + START_W;
    localparam int MW    = (CNT_W > NEED_W) ? CNT_W : NEED_W;
    localparam int CXW   = CNT_W + COUNT_W;

    // reciprocal of the cluster size, exact for every dividend below 2^BYTE_W
    localparam int                 DIV_SH  = BYTE_W + $clog2(CLUSTER_BYTES);
    localparam int                 RECIP_W = BYTE_W + 1;
    localparam int                 PROD_W  = BYTE_W + RECIP_W;
    localparam longint unsigned    RECIP_L = ((64'd1 << DIV_SH) + 64'(CLUSTER_BYTES) - 64'd1)
                                             / 64'(CLUSTER_BYTES);
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);

    // link word: top bit marks end of chain, else the next cluster (zero word is empty)
    localparam logic [LW-1:0]     LINK_EMPTY = '0;
    localparam logic [LW-1:0]     LINK_TERM  = {1'b1, {CW{1'b0}}};
    localparam logic [BYTE_W-1:0] CB_M1      = BYTE_W'(CLUSTER_BYTES - 1);
    localparam logic [BYTE_W-1:0] CB_FULL    = BYTE_W'(CLUSTER_BYTES);

    logic                 r_func;
    logic                 r_bad;
    logic                 r_over;
    logic [BYTE_W-1:0]    r_div;
    logic [NEED_W-1:0]    r_need;
    logic [CW-1:0]        r_cur;
    logic [CNT_W-1:0]     r_cnt;
    logic [CW-1:0]        r_addr;
    logic [CW-1:0]        r_chk;
    logic [CNT_W-1:0]     r_run;
    logic [CW-1:0]        r_run_start;
    logic [CW-1:0]        r_first;
    logic [CW-1:0]        r_link_addr;
    logic [CNT_W-1:0]     r_link_cnt;
    logic [CW-1:0]        r_clr;
    t_out_item            r_out;

    logic [XW-1:0]        w_start_x;
    logic [NEED_W-1:0]    w_need;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_empty;
    logic [CNT_W-1:0]     w_run_nx;
    logic [CW-1:0]        w_run_begin;
    logic                 w_found;
    logic [CNT_W-1:0]     w_link_nx;
    logic                 w_link_last;
    logic [CNT_W-1:0]     w_cnt_nx;
    logic [XW-1:0]        w_first_x;
    logic [CXW-1:0]       w_cnt_x;

    logic                 w_we;
    logic [CW-1:0]        w_waddr;
    logic [LW-1:0]        w_wdata;
    logic [CW-1:0]        w_raddr;
    logic [LW-1:0]        w_rdata;

    fcca_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_CLUSTERS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // input decode
    assign w_start_x = XW'(i_in_data.start_cluster);

    // rounded-up cluster count by reciprocal multiplication
    assign w_prod = PROD_W'(r_div) * PROD_W'(RECIP);
    assign w_need = r_need;

    // first-fit run tracking on the entry just read
    assign w_empty     = (w_rdata == LINK_EMPTY);
    assign w_run_nx    = r_run + CNT_W'(1);
    assign w_run_begin = (r_run == '0) ? r_chk : r_run_start;
    assign w_found     = w_empty && (MW'(w_run_nx) >= MW'(w_need));

    // chain linking and walking counters
    assign w_link_nx   = r_link_cnt + CNT_W'(1);
    assign w_link_last = (MW'(w_link_nx) == MW'(w_need));
    assign w_cnt_nx    = r_cnt + CNT_W'(1);

    // table write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = LINK_EMPTY;
        if (i_cmd.clr_step) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = (r_clr < CW'(RESERVED_CLUSTERS)) ? LINK_TERM : LINK_EMPTY;
        end else if (i_cmd.link_step) begin
            w_we    = 1'b1;
            w_waddr = r_link_addr;
            w_wdata = w_link_last ? LINK_TERM : {1'b0, r_link_addr + CW'(1)};
        end else if (i_cmd.walk_step) begin
            w_we    = 1'b1;
            w_waddr = r_cur;
            w_wdata = LINK_EMPTY;
        end
    end

    // table read address
    always_comb begin
        w_raddr = r_addr;
        if (i_cmd.scan_start) begin
            w_raddr = CW'(FIRST_SEARCH);
        end else if (i_cmd.walk_start) begin
            w_raddr = r_cur;
        end else if (i_cmd.walk_step) begin
            w_raddr = w_rdata[CW-1:0];
        end
    end

    // clearing pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + CW'(1);
        end
    end

    // request capture and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_in_data.func;
            r_bad     <= (w_start_x >= XW'(NUM_CLUSTERS));
            r_over    <= (i_in_data.byte_count > MAX_BYTES);
            r_div     <= (i_in_data.byte_count == '0) ? CB_FULL
                                                      : i_in_data.byte_count + CB_M1;
            r_cur     <= w_start_x[CW-1:0];
            r_cnt     <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_need <= NEED_W'(w_prod >> DIV_SH);
            end
            if (i_cmd.walk_step) begin
                r_cur <= w_rdata[CW-1:0];
                r_cnt <= w_cnt_nx;
            end
        end
    end

    // scan and link registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_addr <= CW'(FIRST_SEARCH + 1);
            r_chk  <= CW'(FIRST_SEARCH);
            r_run  <= '0;
        end else if (i_cmd.scan_step) begin
            r_addr <= r_addr + CW'(1);
            r_chk  <= r_addr;
            r_run  <= w_empty ? w_run_nx : '0;
            if (w_empty && (r_run == '0)) begin
                r_run_start <= r_chk;
            end
            if (w_found) begin
                r_first     <= w_run_begin;
                r_link_addr <= w_run_begin;
                r_link_cnt  <= '0;
            end
        end else if (i_cmd.link_step) begin
            r_link_addr <= r_link_addr + CW'(1);
            r_link_cnt  <= w_link_nx;
        end
    end

    // result register
    assign w_first_x = XW'(r_first);
    assign w_cnt_x   = CXW'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                RES_ALLOC: begin
                    r_out.status        <= STAT_OK;
                    r_out.first_cluster <= w_first_x[FIRST_W-1:0];
                    r_out.cluster_total <= w_need[COUNT_W-1:0];
                end
                RES_FREE: begin
                    r_out.status        <= STAT_OK;
                    r_out.first_cluster <= '0;
                    r_out.cluster_total <= w_cnt_x[COUNT_W-1:0];
                end
                RES_NO_SPACE: begin
                    r_out.status        <= STAT_NO_SPACE;
                    r_out.first_cluster <= '0;
                    r_out.cluster_total <= '0;
                end
                RES_BAD: begin
                    r_out.status        <= STAT_BAD_START;
                    r_out.first_cluster <= '0;
                    r_out.cluster_total <= '0;
                end
            endcase
        end
    end

    assign o_out_data = r_out;

    // status to controller
    always_comb begin
        o_sts.func      = r_func;
        o_sts.bad_start = r_bad;
        o_sts.oversize  = r_over;
        o_sts.clr_last  = (r_clr == CW'(NUM_CLUSTERS - 1));
        o_sts.found     = w_found;
        o_sts.scan_last = (r_chk == CW'(NUM_CLUSTERS - 1));
        o_sts.link_last = w_link_last;
        o_sts.walk_last = w_rdata[CW] || (w_cnt_nx == CNT_W'(NUM_CLUSTERS));
    end

endmodule

`default_nettype wire

[design/fcca_ctrl.sv]
// controller: sequencing of clear, allocate and free, output register valid
`timescale 1ns / 1ps
`default_nettype none

module fcca_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire fcca_pkg::t_sts i_sts,
    output fcca_pkg::t_cmd      o_cmd
);
    import fcca_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_DIV      = 4'd3;
    localparam logic [3:0] S_SSTART   = 4'd4;
    localparam logic [3:0] S_SCAN     = 4'd5;
    localparam logic [3:0] S_LINK     = 4'd6;
    localparam logic [3:0] S_WSTART   = 4'd7;
    localparam logic [3:0] S_WALK     = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_res       r_sel;
    t_res       n_sel;
    logic       r_out_vld;
    logic       n_out_vld;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        o_cmd         = '0;
        o_cmd.out_sel = r_sel;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.func == FUNC_FREE) begin
                    if (i_sts.bad_start) begin
                        n_sel   = RES_BAD;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WSTART;
                    end
                end else if (i_sts.oversize) begin
                    n_sel   = RES_NO_SPACE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_SSTART;
            end
            S_SSTART: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.found) begin
                    n_state = S_LINK;
                end else if (i_sts.scan_last) begin
                    n_sel   = RES_NO_SPACE;
                    n_state = S_DONE;
                end
            end
            S_LINK: begin
                o_cmd.link_step = 1'b1;
                if (i_sts.link_last) begin
                    n_sel   = RES_ALLOC;
                    n_state = S_DONE;
                end
            end
            S_WSTART: begin
                o_cmd.walk_start = 1'b1;
                n_state          = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_sel   = RES_FREE;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_sel     <= RES_NO_SPACE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

[design/fat_cluster_chain_allocator.sv]
// top level of the fat cluster chain allocator
// one transaction at a time; the link table sits in one ram with one read and one write a cycle
// allocate: dispatch, divide, then a first-fit scan of k entries from cluster 3, then n clusters linked
// free: walks a chain of n clusters (n at most NUM_CLUSTERS)
// the worst case is set by the scan and link passes over the ram
// next transaction is taken the cycle after the result enters the output register
// after reset a clearing pass writes every table entry while input is stalled
`timescale 1ns / 1ps
`default_nettype none

module fat_cluster_chain_allocator #(
    parameter int NUM_CLUSTERS  = 512,
    parameter int CLUSTER_BYTES = 2048
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire fcca_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output fcca_pkg::t_out_item      o_out_data
);
    import fcca_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    fcca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fcca_dpath #(
        .NUM_CLUSTERS  (NUM_CLUSTERS),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

    // a taken transaction keeps the input stalled until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // failed results carry no cluster and no count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != STAT_OK)) |->
        ((o_out_data.first_cluster == '0) && (o_out_data.cluster_total == '0)))
        else $error("failed result with nonzero cluster or count");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output register loaded over a stalled result");

    // no transaction is taken while the table is being cleared
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_step |-> o_in_stall)
        else $error("input open during the clearing pass");

endmodule

`default_nettype wire

[bench/fat_cluster_chain_allocator_tb.sv]
// testbench for the cluster chain allocator: directed table, then random transactions
`timescale 1ns / 1ps

module fat_cluster_chain_allocator_tb;
    import fcca_pkg::*;

    localparam int N_CLUSTERS = 512;
    localparam int CL_BYTES   = 2048;

    localparam logic [31:0] LINK_EMPTY = 32'h0000_0000;
    localparam logic [31:0] LINK_END   = 32'h0FFF_FFFF;
    localparam logic [31:0] LINK_RES0  = 32'h0FFF_FFF8;

    localparam int RANDOM_OPS   = 516;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int MAX_REPORTS  = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    fat_cluster_chain_allocator #(
        .NUM_CLUSTERS (N_CLUSTERS),
        .CLUSTER_BYTES(CL_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state and expected results
    logic [31:0]        model_links [N_CLUSTERS];
    t_out_item          pending_results [$];
    logic [START_W-1:0] live_heads [$];
    int                 mismatches  = 0;
    int                 idle_cycles = 0;
    int                 stall_run;
    bit                 calm = 1'b0;
    t_out_item          want;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_dir_row;

    t_dir_row dir_rows [$];

    // allocate or free one chain in the predictor's link table
    function automatic t_out_item apply_cluster_op(input t_in_item it);
        t_out_item   r;
        int          need;
        int          run_start;
        int          run_len;
        int          first;
        int          cur;
        int          cnt;
        logic [31:0] nxt;
        bit          found;
        r = '0;
        if (it.func == FUNC_ALLOC) begin
            if (it.byte_count > MAX_BYTES) begin
                r.status = STAT_NO_SPACE;
                return r;
            end
            need = (it.byte_count == '0) ? 1 : (int'(it.byte_count) + CL_BYTES - 1) / CL_BYTES;
            // first fit from the first searchable cluster
            found     = 1'b0;
            run_len   = 0;
            run_start = 0;
            first     = 0;
            for (int i = FIRST_SEARCH; i < N_CLUSTERS && !found; i++) begin
                if (model_links[i] == LINK_EMPTY) begin
                    if (run_len == 0) run_start = i;
                    run_len++;
                    if (run_len >= need) begin
                        found = 1'b1;
                        first = run_start;
                    end
                end else begin
                    run_len = 0;
                end
            end
            if (!found) begin
                r.status = STAT_NO_SPACE;
                return r;
            end
            // link the run in ascending order
            for (int i = 0; i < need; i++)
                model_links[first + i] = (i + 1 == need) ? LINK_END : 32'(first + i + 1);
            r.status        = STAT_OK;
            r.first_cluster = FIRST_W'(first);
            r.cluster_total = COUNT_W'(need);
        end else begin
            if (int'(it.start_cluster) >= N_CLUSTERS) begin
                r.status = STAT_BAD_START;
                return r;
            end
            // walk the chain, bounded by the table size
            cur = int'(it.start_cluster);
            cnt = 0;
            while (cnt < N_CLUSTERS) begin
                nxt = model_links[cur];
                model_links[cur] = LINK_EMPTY;
                cnt++;
                if (nxt == LINK_END || nxt >= N_CLUSTERS) break;
                cur = int'(nxt);
            end
            r.status        = STAT_OK;
            r.cluster_total = COUNT_W'(cnt);
        end
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_in_item mk_alloc(input int bytes);
        t_in_item it;
        it.func          = FUNC_ALLOC;
        it.byte_count    = BYTE_W'(bytes);
        it.start_cluster = START_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk_free(input int start);
        t_in_item it;
        it.func          = FUNC_FREE;
        it.byte_count    = BYTE_W'($urandom);
        it.start_cluster = START_W'(start);
        return it;
    endfunction

    task automatic add_row(input t_in_item it, input bit typed,
                           input logic [STATUS_W-1:0] st, input int first, input int cnt);
        t_dir_row row;
        row.item                = it;
        row.typed               = typed;
        row.res.status          = st;
        row.res.first_cluster   = FIRST_W'(first);
        row.res.cluster_total   = COUNT_W'(cnt);
        dir_rows.push_back(row);
    endtask

    // mostly well-formed alloc and free of live chains, some stray frees and oversize
    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        int       k;
        it.func          = FUNC_ALLOC;
        it.byte_count    = BYTE_W'($urandom);
        it.start_cluster = START_W'($urandom);
        if (live_heads.size() > 0 && $urandom_range(0, 99) < 45) begin
            it.func = FUNC_FREE;
            r = $urandom_range(0, 99);
            k = $urandom_range(0, live_heads.size() - 1);
            if (r < 80) begin
                it.start_cluster = live_heads[k];
                live_heads.delete(k);
            end else if (r < 90) begin
                // start part way along a chain
                it.start_cluster = START_W'(live_heads[k] + $urandom_range(1, 3));
            end
        end else begin
            r = $urandom_range(0, 99);
            if (r < 10)
                it.byte_count = '0;
            else if (r < 70)
                it.byte_count = BYTE_W'($urandom_range(1, 8 * CL_BYTES));
            else if (r < 80)
                it.byte_count = BYTE_W'(CL_BYTES * $urandom_range(1, 16));
            else if (r < 93)
                it.byte_count = BYTE_W'($urandom_range(1, MAX_BYTES));
            else
                it.byte_count = BYTE_W'($urandom_range(MAX_BYTES + 1, 2 ** BYTE_W - 1));
        end
        return it;
    endfunction

    // present one transaction, wait for acceptance, record what should come back
    task automatic drive_op(input t_in_item it, input bit typed, input t_out_item typed_res);
        int        gap;
        t_out_item predicted;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_cluster_op(it);
        pending_results.push_back(typed ? typed_res : predicted);
        if (it.func == FUNC_ALLOC && predicted.status == STAT_OK)
            live_heads.push_back(predicted.first_cluster);
    endtask

    task automatic report_mismatch(input string what, input t_out_item exp_res,
                                   input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: status/first/count expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     $realtime, what, exp_res.status, exp_res.first_cluster,
                     exp_res.cluster_total, got.status, got.first_cluster,
                     got.cluster_total);
    endtask

    // result side stalls
    initial begin
        forever begin
            stall_run = pick_gap();
            @(negedge i_clk);
            if (stall_run > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_run) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.first_cluster !== want.first_cluster ||
                    o_out_data.cluster_total !== want.cluster_total)
                    report_mismatch("result mismatch", want, o_out_data);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("** fat_cluster_chain_allocator: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        // predictor table after reset
        for (int i = 0; i < N_CLUSTERS; i++) model_links[i] = LINK_EMPTY;
        model_links[0] = LINK_RES0;
        model_links[1] = LINK_END;
        model_links[2] = LINK_END;

        // directed table, typed where the answer is plain
        add_row(mk_alloc(0),          1'b1, STAT_OK, 3, 1);
        add_row(mk_alloc(1),          1'b1, STAT_OK, 4, 1);
        add_row(mk_alloc(CL_BYTES),   1'b1, STAT_OK, 5, 1);
        add_row(mk_alloc(CL_BYTES+1), 1'b1, STAT_OK, 6, 2);
        add_row(mk_alloc(2 ** BYTE_W - 1),     1'b1, STAT_NO_SPACE, 0, 0);
        add_row(mk_alloc(int'(MAX_BYTES) + 1), 1'b1, STAT_NO_SPACE, 0, 0);
        add_row(mk_alloc(int'(MAX_BYTES)),     1'b1, STAT_NO_SPACE, 0, 0);
        add_row(mk_free(6),                    1'b1, STAT_OK, 0, 2);
        add_row(mk_alloc(2 * CL_BYTES),        1'b1, STAT_OK, 6, 2);
        // reserved clusters are walked like any other
        add_row(mk_free(0),   1'b1, STAT_OK, 0, 1);
        add_row(mk_free(1),   1'b1, STAT_OK, 0, 1);
        add_row(mk_free(2),   1'b1, STAT_OK, 0, 1);
        // empty entries lead on to cluster 0, a cycle bounded by the table size
        add_row(mk_free(0),   1'b1, STAT_OK, 0, N_CLUSTERS);
        add_row(mk_free(100), 1'b1, STAT_OK, 0, N_CLUSTERS);
        add_row(mk_free(4),   1'b0, STAT_OK, 0, 0);
        add_row(mk_free(5),   1'b0, STAT_OK, 0, 0);
        add_row(mk_free(3),   1'b0, STAT_OK, 0, 0);
        add_row(mk_free(6),   1'b0, STAT_OK, 0, 0);
        // whole searchable table in one run, then full
        add_row(mk_alloc((N_CLUSTERS - 3) * CL_BYTES), 1'b1, STAT_OK, 3, N_CLUSTERS - 3);
        add_row(mk_alloc(0),  1'b1, STAT_NO_SPACE, 0, 0);
        // free from mid chain, refill the gap
        add_row(mk_free(250), 1'b0, STAT_OK, 0, 0);
        add_row(mk_alloc((N_CLUSTERS - 250) * CL_BYTES), 1'b0, STAT_OK, 0, 0);
        add_row(mk_free(3),   1'b1, STAT_OK, 0, N_CLUSTERS - 3);
        add_row(mk_free(N_CLUSTERS - 1), 1'b0, STAT_OK, 0, 0);

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            drive_op(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

        // random part, with stretches of no idling
        for (int n = 0; n < RANDOM_OPS; n++) begin
            calm = (n % 90) >= 70;
            drive_op(random_item(), 1'b0, '0);
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("** fat_cluster_chain_allocator: PASSED **");
        else
            $display("** fat_cluster_chain_allocator: FAILED **");
        $finish;
    end

endmodule

[files.f]
design/fcca_pkg.sv
design/fcca_ram.sv
design/fcca_dpath.sv
design/fcca_ctrl.sv
design/fat_cluster_chain_allocator.sv
bench/fat_cluster_chain_allocator_tb.sv
